>>> hdl/radix_digit_converter_macros.svh
// assertion macros for the radix digit converter
// used by rdc_ctrl and rdc_datapath; expects clk and rst_n in scope
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rdc_pkg.sv
// shared types and constants of the radix digit converter
// no dependencies; imported by every module of the block but the ram
`default_nettype none

package rdc_pkg;

  localparam int unsigned VALUE_WIDTH = 31;
  localparam int unsigned DIGIT_DEPTH = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = RADIX_W;
  localparam int unsigned CNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_radix;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;            // capture item, clear divider and stack
    logic div_step;        // one quotient bit
    logic push;            // push remainder, start next digit
    logic pop_rd;          // read top of stack
    logic out_load_digit;  // move popped digit into output register
    logic out_load_bad;    // output the bad-radix beat
  } rdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic radix_bad;   // radix of the offered item is out of range
    logic div_done;    // current step is the last bit of the division
    logic quot_zero;   // quotient after the division is zero
    logic last_pend;   // digit just read is the final one
    logic out_free;    // output register can take a beat this cycle
  } rdc_sts_t;

endpackage

`default_nettype wire

>>> hdl/radix_digit_converter.sv
// top level of the radix digit converter
// depends on rdc_pkg, rdc_ctrl, rdc_datapath (which holds rdc_ram)
`default_nettype none

// Converts a non-negative integer into its digits in a base from 2 to 36.
// Each input beat (value, radix) yields one output beat per digit, most
// significant digit first, with last set on the final digit. A zero value
// gives the single digit 0. A radix outside 2..36 gives exactly one beat with
// digit 0, last 1 and bad_radix 1. Items are handled one at a time; a new
// input beat is taken once the final digit of the previous item has been
// placed in the output register, even if that beat is still waiting.
// For each item the block takes the input beat, then for each digit divides
// with the shared restoring divider, which produces one quotient bit per
// cycle, and pushes the remainder onto the stack ram; then it pops the stack
// digit by digit (read, then load into the output register), waiting
// whenever the output side stalls. For a bad radix the block skips the
// division and only waits to load the bad-radix beat.
module radix_digit_converter
  import rdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input beats
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  // digit beats
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  // command and status between sequencer and datapath
  rdc_cmd_t cmd;
  rdc_sts_t sts;

  // sequencer: divide loop, stack pop and output handoff
  rdc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // divider, digit stack and output register
  rdc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/rdc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/rdc_datapath.sv
// datapath: bit-serial restoring divider, digit stack and output register
// depends on rdc_pkg, rdc_ram and radix_digit_converter_macros.svh
`default_nettype none
`include "radix_digit_converter_macros.svh"

module rdc_datapath
  import rdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire rdc_cmd_t  cmd,
  output      rdc_sts_t  sts,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   last_pend_r, last_pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic [RADIX_W:0]   shifted;
  logic [RADIX_W-1:0] diff;
  logic               ge;
  logic               bit_last;
  logic               stack_room;
  logic [CNT_W-1:0]   cnt_m1;
  logic [DIGIT_W-1:0] ram_rdata;

  // trial subtraction for one quotient bit; the difference is below the radix
  assign shifted    = {rem_r, q_r[VALUE_WIDTH-1]};
  assign diff       = shifted[RADIX_W-1:0] - radix_r;
  assign ge         = shifted >= {1'b0, radix_r};
  assign bit_last   = bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1);
  assign stack_room = cnt_r < CNT_W'(DIGIT_DEPTH);
  assign cnt_m1     = cnt_r - CNT_W'(1);

  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    last_pend_nxt = last_pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      q_nxt       = in_data.value;
      radix_nxt   = in_data.radix;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      cnt_nxt     = '0;
    end
    if (cmd.div_step) begin
      q_nxt       = {q_r[VALUE_WIDTH-2:0], ge};
      rem_nxt     = ge ? diff : shifted[RADIX_W-1:0];
      bit_cnt_nxt = bit_last ? '0 : bit_cnt_r + BIT_CNT_W'(1);
    end
    if (cmd.push) begin
      rem_nxt = '0;
      if (stack_room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.pop_rd) begin
      cnt_nxt       = cnt_m1;
      last_pend_nxt = cnt_m1 == '0;
    end
    if (cmd.out_load_digit) begin
      out_nxt.digit     = ram_rdata;
      out_nxt.last      = last_pend_r;
      out_nxt.bad_radix = 1'b0;
      out_valid_nxt     = 1'b1;
    end
    if (cmd.out_load_bad) begin
      out_nxt.digit     = '0;
      out_nxt.last      = 1'b1;
      out_nxt.bad_radix = 1'b1;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      last_pend_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_pend_r <= last_pend_nxt;
    end
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    out_r   <= out_nxt;
  end

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(DIGIT_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push && stack_room),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(rem_r),
    .re   (cmd.pop_rd),
    .raddr(cnt_m1[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign sts.radix_bad = (in_data.radix < MIN_RADIX) || (in_data.radix > MAX_RADIX);
  assign sts.div_done  = bit_last;
  assign sts.quot_zero = q_r == '0;
  assign sts.last_pend = last_pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RDC_ASSERT_NOW(a_no_overwrite, cmd.out_load_digit || cmd.out_load_bad,
    !out_valid_r || out_ready, "output beat overwritten before it was taken")
  `RDC_ASSERT_NOW(a_pop_nonempty, cmd.pop_rd, cnt_r != '0, "pop from an empty digit stack")

endmodule

`default_nettype wire

>>> hdl/rdc_ctrl.sv
// controller state machine: sequences divide, push, pop and output
// depends on rdc_pkg and radix_digit_converter_macros.svh
`default_nettype none
`include "radix_digit_converter_macros.svh"

module rdc_ctrl
  import rdc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire rdc_sts_t sts,
  output      rdc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_PUSH   = 3'd2;
  localparam logic [2:0] S_POP_RD = 3'd3;
  localparam logic [2:0] S_POP_LD = 3'd4;
  localparam logic [2:0] S_BAD    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.radix_bad) begin
            state_nxt = S_BAD;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = sts.quot_zero ? S_POP_RD : S_DIV;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        if (sts.out_free) begin
          cmd.out_load_digit = 1'b1;
          state_nxt          = sts.last_pend ? S_IDLE : S_POP_RD;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.out_load_bad = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RDC_ASSERT_NEXT(a_div_to_push, state_r == S_DIV && sts.div_done, state_r == S_PUSH,
    "division did not end in a push")
  `RDC_ASSERT_NEXT(a_last_to_idle, cmd.out_load_digit && sts.last_pend, in_ready,
    "final digit did not return to idle")
  `RDC_ASSERT_NOW(a_cmd_onehot, 1'b1,
    $onehot0({cmd.load, cmd.div_step, cmd.push, cmd.pop_rd, cmd.out_load_digit,
              cmd.out_load_bad}), "more than one datapath command at once")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for radix_digit_converter
// depends on rdc_pkg and the radix_digit_converter rtl; holds its own digit scoreboard
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 64;
  localparam int unsigned TAIL_CYCLES     = 120;   // a few pop cycles plus margin
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned BAD_RADIX_PCT   = 8;

  // scoreboard: turns every accepted (value, radix) beat into the digit beats
  // the block owes, then matches digit beats against them in order
  class digit_scoreboard;
    out_item_t   expected_digits[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_digits.size();
    endfunction

    function void flag(string msg);
      if (mismatches < MAX_REPORTS) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endfunction

    // repeated division by the radix, remainders stacked, popped msd first
    function void note_conversion(in_item_t it);
      logic [VALUE_WIDTH-1:0] rest;
      logic [DIGIT_W-1:0]     stack [DIGIT_DEPTH];
      int unsigned            depth;
      out_item_t              beat;
      if (it.radix < MIN_RADIX || it.radix > MAX_RADIX) begin
        beat.digit     = '0;
        beat.last      = 1'b1;
        beat.bad_radix = 1'b1;
        expected_digits.push_back(beat);
        return;
      end
      rest  = it.value;
      depth = 0;
      if (rest == '0) begin
        stack[0] = '0;
        depth    = 1;
      end
      while (rest != '0) begin
        // remainders beyond the stack depth are dropped
        if (depth < DIGIT_DEPTH) begin
          stack[depth] = DIGIT_W'(rest % it.radix);
          depth++;
        end
        rest = rest / it.radix;
      end
      for (int k = int'(depth) - 1; k >= 0; k--) begin
        beat.digit     = stack[k];
        beat.last      = (k == 0);
        beat.bad_radix = 1'b0;
        expected_digits.push_back(beat);
      end
    endfunction

    function void check_digit(out_item_t got);
      out_item_t want;
      if (expected_digits.size() == 0) begin
        flag($sformatf("unexpected beat digit=%0d last=%0b bad_radix=%0b",
                       got.digit, got.last, got.bad_radix));
        return;
      end
      want = expected_digits.pop_front();
      if (got.digit !== want.digit) begin
        flag($sformatf("digit expected %0d got %0d", want.digit, got.digit));
      end
      if (got.last !== want.last) begin
        flag($sformatf("last expected %0b got %0b", want.last, got.last));
      end
      if (got.bad_radix !== want.bad_radix) begin
        flag($sformatf("bad_radix expected %0b got %0b", want.bad_radix, got.bad_radix));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // idle chances in percent, changed between phases only
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  digit_scoreboard digits_sb = new();

  radix_digit_converter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run: every item at 31 binary
  // digits, with stalls on both sides
  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_item_t make_item(logic [VALUE_WIDTH-1:0] v, logic [RADIX_W-1:0] r);
    in_item_t it;
    it.value = v;
    it.radix = r;
    return it;
  endfunction

  // mostly legal bases; value widths skewed small so long binary
  // conversions stay a minority, with an occasional full-width value
  function automatic in_item_t random_item();
    in_item_t               it;
    int unsigned            w;
    logic [VALUE_WIDTH-1:0] mask;
    if ($urandom_range(0, 99) < BAD_RADIX_PCT) begin
      if ($urandom_range(0, 1) != 0) begin
        it.radix = RADIX_W'($urandom_range(0, 1));
      end else begin
        it.radix = RADIX_W'($urandom_range(37, 63));
      end
    end else begin
      it.radix = RADIX_W'($urandom_range(2, 36));
    end
    if ($urandom_range(0, 9) == 0) begin
      w = VALUE_WIDTH;
    end else begin
      w = $urandom_range(0, 20);
    end
    mask     = (w >= VALUE_WIDTH) ? '1 : VALUE_WIDTH'((64'd1 << w) - 64'd1);
    it.value = VALUE_WIDTH'($urandom) & mask;
    return it;
  endfunction

  // offer one input beat after a random gap and hold it until taken;
  // in_valid is left high so back-to-back beats need no toggle
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    digits_sb.note_conversion(it);
  endtask

  // sender holds off until every owed digit beat has come back
  task automatic drain_digits();
    in_valid <= 1'b0;
    do @(posedge clk); while (digits_sb.pending() != 0);
  endtask

  task automatic run_directed();
    // zero value in several bases, one digit each
    send_item(make_item('0, 6'd2));
    send_item(make_item('0, 6'd10));
    send_item(make_item('0, MAX_RADIX));
    // smallest nonzero and the digit-rollover points
    send_item(make_item(31'd1, MIN_RADIX));
    send_item(make_item(31'd2, MIN_RADIX));
    send_item(make_item(31'd35, MAX_RADIX));
    send_item(make_item(31'd36, MAX_RADIX));
    // full-scale value: 31 binary digits is the deepest stack
    send_item(make_item('1, MIN_RADIX));
    send_item(make_item('1, 6'd3));
    send_item(make_item('1, 6'd10));
    send_item(make_item('1, 6'd32));
    send_item(make_item('1, MAX_RADIX));
    send_item(make_item(31'h2AAA_AAAA, 6'd8));
    send_item(make_item(31'h5555_5555, MIN_RADIX));
    send_item(make_item(31'd255, 6'd16));
    send_item(make_item(31'd1_000_000, 6'd10));
    // bad bases below 2 and above 36, with zero, mid and full values, then a legal base-2 item
    send_item(make_item('0, 6'd0));
    send_item(make_item('1, 6'd1));
    send_item(make_item(31'd12345, 6'd37));
    send_item(make_item('1, 6'd63));
    send_item(make_item(31'd7, 6'd2));
  endtask

  task automatic run_phase(int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (ITEMS_PER_PHASE) send_item(random_item());
    drain_digits();
  endtask

  // digit side: check every accepted beat, then pick the next ready value
  initial begin
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_valid && out_ready) begin
        digits_sb.check_digit(out_data);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_digits();

    // sender sparse receiver busy, then swapped, then full rate both ways
    run_phase(19, 68);
    run_phase(68, 19);
    run_phase(0, 0);

    // quiet tail catches any stray beat after the last expected digit
    repeat (TAIL_CYCLES) @(posedge clk);
    if (digits_sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> radix_digit_converter.f
+incdir+hdl
hdl/rdc_pkg.sv
hdl/rdc_ram.sv
hdl/rdc_datapath.sv
hdl/rdc_ctrl.sv
hdl/radix_digit_converter.sv
tb/testbench.sv
